// ===== rtl/core/flt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Flow table package
// Types, opcodes and defaults shared by the flow table modules.
// ----------------------------------------------------------------------------
package flt_pkg;

	localparam int ENTRIES_DEF = 16;
	localparam int SLOT_W      = 4;
	localparam int AGE_W       = 32;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_INSERT = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_RSVD   = 2'd3
	} op_t;

	typedef struct packed {
		op_t         opcode;
		logic [31:0] src_addr;
		logic [15:0] src_port;
		logic [31:0] dst_addr;
		logic [15:0] dst_port;
		logic        class_flag;
	} cmd_t;

	typedef struct packed {
		logic              hit;
		logic              class_out;
		logic [SLOT_W-1:0] slot;
	} res_t;

	typedef struct packed {
		logic [31:0] src_addr;
		logic [15:0] src_port;
		logic [31:0] dst_addr;
		logic [15:0] dst_port;
	} tuple_t;

	typedef struct packed {
		logic clear;
		logic stamp;
		logic load;
		logic set_class;
	} wr_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/flt_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Flow table entry store
// Valid bits, tuples and class flags with parallel match and free search.
// ----------------------------------------------------------------------------
module flt_store #(
	parameter  int ENTRIES = flt_pkg::ENTRIES_DEF,
	localparam int IDXW    = $clog2(ENTRIES)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire flt_pkg::tuple_t  key,
	input  wire logic             cls,
	input  wire flt_pkg::wr_ctl_t ctl,
	input  wire logic [IDXW-1:0]  wr_idx,
	output logic                  match_hit,
	output logic [IDXW-1:0]       match_idx,
	output logic                  match_class,
	output logic                  free_any,
	output logic [IDXW-1:0]       free_idx
);

	logic [ENTRIES-1:0] valid_q;
	logic [ENTRIES-1:0] class_q;
	flt_pkg::tuple_t    tuple_q [ENTRIES];
	logic [ENTRIES-1:0] match_vec;

	always_comb begin
		for (int k = 0; k < ENTRIES; k++) begin
			match_vec[k] = valid_q[k] && (tuple_q[k] == key);
		end
	end

	always_comb begin
		match_hit = |match_vec;
		match_idx = '0;
		for (int k = ENTRIES - 1; k >= 0; k--) begin
			if (match_vec[k]) begin
				match_idx = IDXW'(k);
			end
		end
	end

	always_comb begin
		free_any = ~&valid_q;
		free_idx = '0;
		for (int k = ENTRIES - 1; k >= 0; k--) begin
			if (!valid_q[k]) begin
				free_idx = IDXW'(k);
			end
		end
	end

	assign match_class = class_q[match_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.clear) begin
			valid_q <= '0;
		end else if (ctl.load) begin
			valid_q[wr_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			tuple_q[wr_idx] <= key;
		end
		if (ctl.set_class) begin
			class_q[wr_idx] <= cls;
		end
	end

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |=> valid_q[$past(wr_idx)])
		else $error("loaded entry not valid");

endmodule
`default_nettype wire

// ===== rtl/core/flt_age.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Flow table age tracker
// Age counter, per-entry stamps and a pairwise order matrix that names the
// entry with the smallest stamp, lowest index first on ties.
// ----------------------------------------------------------------------------
module flt_age #(
	parameter  int ENTRIES = flt_pkg::ENTRIES_DEF,
	localparam int IDXW    = $clog2(ENTRIES)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire flt_pkg::wr_ctl_t ctl,
	input  wire logic [IDXW-1:0]  wr_idx,
	output logic [IDXW-1:0]       victim_idx
);

	logic [flt_pkg::AGE_W-1:0] cnt_q;
	logic [flt_pkg::AGE_W-1:0] age_q [ENTRIES];
	logic [ENTRIES-1:0]        lt_q  [ENTRIES];
	logic [flt_pkg::AGE_W-1:0] stamp_v;
	logic [ENTRIES-1:0]        newer;
	logic [ENTRIES-1:0]        older;
	logic [ENTRIES-1:0]        sel;

	assign stamp_v = cnt_q + flt_pkg::AGE_W'(1);

	always_comb begin
		for (int j = 0; j < ENTRIES; j++) begin
			newer[j] = stamp_v < age_q[j];
			older[j] = age_q[j] < stamp_v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			age_q <= '{default: '0};
			lt_q  <= '{default: '0};
		end else if (ctl.clear) begin
			cnt_q <= '0;
			age_q <= '{default: '0};
			lt_q  <= '{default: '0};
		end else if (ctl.stamp) begin
			cnt_q          <= stamp_v;
			age_q[wr_idx]  <= stamp_v;
			for (int i = 0; i < ENTRIES; i++) begin
				for (int j = 0; j < ENTRIES; j++) begin
					if (i != j) begin
						if (IDXW'(i) == wr_idx) begin
							lt_q[i][j] <= newer[j];
						end else if (IDXW'(j) == wr_idx) begin
							lt_q[i][j] <= older[i];
						end
					end
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			sel[i] = 1'b1;
			for (int j = 0; j < ENTRIES; j++) begin
				if (j < i) begin
					sel[i] = sel[i] & lt_q[i][j];
				end else if (j > i) begin
					sel[i] = sel[i] & ~lt_q[j][i];
				end
			end
		end
	end

	always_comb begin
		victim_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (sel[i]) begin
				victim_idx = IDXW'(i);
			end
		end
	end

	a_stamp_advances: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.stamp |=> cnt_q == $past(cnt_q) + flt_pkg::AGE_W'(1))
		else $error("age counter did not advance on stamp");

endmodule
`default_nettype wire

// ===== rtl/core/flow_table_lru.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fully associative flow table with LRU replacement
// One command per cycle while cmd_stall is low: clear, insert or update, lookup of a 4-tuple.
// ----------------------------------------------------------------------------
// The block takes one command every cycle while cmd_stall is low. A
// command in the input register has its result written to the result
// register, which drives res until it transfers out. The match over all
// entries, the lowest free entry search and the replacement pick all
// resolve in a single pass between the input register and the result
// register; replacement reads a pairwise stamp order matrix that is updated
// with every stamp, so no minimum search runs per command. A stalled result
// holds the input register, and cmd_stall rises only while both are full.
// ----------------------------------------------------------------------------
module flow_table_lru #(
	parameter int ENTRIES = flt_pkg::ENTRIES_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	output logic               cmd_stall,
	input  wire flt_pkg::cmd_t cmd,
	output logic               res_valid,
	input  wire logic          res_stall,
	output flt_pkg::res_t      res
);

	localparam int IDXW = $clog2(ENTRIES);

	logic                 valid_s1;
	flt_pkg::cmd_t        cmd_s1;
	logic                 advance;
	logic                 fire;
	flt_pkg::tuple_t      key;
	flt_pkg::wr_ctl_t     ctl;
	logic [IDXW-1:0]      wr_idx;
	logic                 m_hit;
	logic [IDXW-1:0]      match_idx;
	logic                 m_class;
	logic                 f_any;
	logic [IDXW-1:0]      free_idx;
	logic [IDXW-1:0]      victim_idx;
	logic [flt_pkg::SLOT_W+IDXW-1:0] idx_ext;
	flt_pkg::res_t        rslt;
	flt_pkg::res_t        res_q;
	logic                 res_valid_q;

	assign advance   = !res_valid_q || !res_stall;
	assign fire      = valid_s1 && advance;
	assign cmd_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!cmd_stall && cmd_valid) begin
			cmd_s1 <= cmd;
		end
	end

	assign key = '{src_addr: cmd_s1.src_addr, src_port: cmd_s1.src_port,
		dst_addr: cmd_s1.dst_addr, dst_port: cmd_s1.dst_port};

	flt_store #(.ENTRIES(ENTRIES)) u_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.key         (key),
		.cls         (cmd_s1.class_flag),
		.ctl         (ctl),
		.wr_idx      (wr_idx),
		.match_hit   (m_hit),
		.match_idx   (match_idx),
		.match_class (m_class),
		.free_any    (f_any),
		.free_idx    (free_idx)
	);

	flt_age #(.ENTRIES(ENTRIES)) u_age (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.wr_idx     (wr_idx),
		.victim_idx (victim_idx)
	);

	assign idx_ext = {{flt_pkg::SLOT_W{1'b0}}, wr_idx};

	always_comb begin
		ctl    = '0;
		wr_idx = match_idx;
		rslt   = '0;
		unique case (cmd_s1.opcode)
			flt_pkg::OP_CLEAR: begin
				ctl.clear = fire;
			end
			flt_pkg::OP_INSERT: begin
				ctl.stamp     = fire;
				ctl.set_class = fire;
				if (m_hit) begin
					rslt.hit = 1'b1;
				end else begin
					ctl.load = fire;
					wr_idx   = f_any ? free_idx : victim_idx;
				end
				rslt.class_out = cmd_s1.class_flag;
				rslt.slot      = idx_ext[flt_pkg::SLOT_W-1:0];
			end
			flt_pkg::OP_LOOKUP: begin
				if (m_hit) begin
					ctl.stamp      = fire;
					rslt.hit       = 1'b1;
					rslt.class_out = m_class;
					rslt.slot      = idx_ext[flt_pkg::SLOT_W-1:0];
				end
			end
			flt_pkg::OP_RSVD: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= rslt;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire && cmd_s1.opcode == flt_pkg::OP_CLEAR |=>
		res_valid && !res.hit && !res.class_out && res.slot == '0)
		else $error("clear result not zero");

	a_lookup_miss: assert property (@(posedge clk) disable iff (!arst_n)
		fire && cmd_s1.opcode == flt_pkg::OP_LOOKUP && !m_hit |=>
		res_valid && !res.hit && !res.class_out && res.slot == '0)
		else $error("lookup miss reported a hit");

endmodule
`default_nettype wire
